// File: hdl/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg: shared constants and helpers for the haversine distance pipeline
// Fixed-point constants (Q.30), arctangent table and widths used by all stages.
// ----------------------------------------------------------------------------
package hvd_pkg;

    localparam int ANGLE_FRAC_BITS = 29;
    localparam int CORDIC_STEPS    = 28;

    // Internal angle / value width: Q.30 values up to about +-2*pi plus growth
    localparam int DW = 36;

    localparam logic signed [DW-1:0] Q30_ONE     = 36'sd1073741824;
    localparam logic signed [DW-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [DW-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [DW-1:0] Q30_TWO_PI  = 36'sd6746518853;
    localparam logic signed [DW-1:0] Q30_GAIN    = 36'sd652032874;

    localparam logic [23:0] RADIUS_RESET = 24'd6371000;
    localparam logic [25:0] DIST_MAX     = 26'd52706457;

    localparam logic [1:0] ADDR_RADIUS = 2'd0;

    typedef logic signed [DW-1:0] q_t;

    // Arctangent of 2^-i in Q.30
    function automatic q_t atan_q30(input int i);
        case (i)
            0:  atan_q30 = 36'sd843314857;
            1:  atan_q30 = 36'sd497837829;
            2:  atan_q30 = 36'sd263043837;
            3:  atan_q30 = 36'sd133525159;
            4:  atan_q30 = 36'sd67021687;
            5:  atan_q30 = 36'sd33543516;
            6:  atan_q30 = 36'sd16775851;
            7:  atan_q30 = 36'sd8388437;
            8:  atan_q30 = 36'sd4194283;
            9:  atan_q30 = 36'sd2097149;
            default:
                atan_q30 = (i < 31) ? q_t'(36'sd1 <<< (30 - i)) : '0;
        endcase
    endfunction

    // Clamp to [-1, 1]
    function automatic q_t clamp_one(input q_t v);
        if (v > Q30_ONE)
            clamp_one = Q30_ONE;
        else if (v < -Q30_ONE)
            clamp_one = -Q30_ONE;
        else
            clamp_one = v;
    endfunction

    // Q.30 product rounded half up
    function automatic q_t mul_q30(input q_t a, input q_t b);
        logic signed [2*DW-1:0] p;
        p = a * b + (2*DW)'(64'sd536870912);
        mul_q30 = q_t'(p >>> 30);
    endfunction

endpackage

// File: hdl/hvd_cordic_rot.sv
// ----------------------------------------------------------------------------
// hvd_cordic_rot: pipelined rotation CORDIC for sin and cos
// Range reduction in the first stage, one micro-rotation per stage after it.
// ----------------------------------------------------------------------------
module hvd_cordic_rot
    import hvd_pkg::*;
(
    input  logic clk,
    input  logic adv,
    input  q_t   ang,
    output q_t   sin_q,
    output q_t   cos_q
);

    q_t   t_reg [0:CORDIC_STEPS];
    q_t   x_reg [0:CORDIC_STEPS];
    q_t   y_reg [0:CORDIC_STEPS];
    logic f_reg [0:CORDIC_STEPS];

    q_t   t_red;
    q_t   t_next;
    logic flip_next;

    // Reduce angle into [-pi/2, pi/2] with fold flag
    always_comb
    begin
        t_red = ang;
        if (t_red > Q30_PI)
            t_red = t_red - Q30_TWO_PI;
        if (t_red < -Q30_PI)
            t_red = t_red + Q30_TWO_PI;
        flip_next = 1'b0;
        t_next    = t_red;
        if (t_red > Q30_HALF_PI)
        begin
            t_next    = Q30_PI - t_red;
            flip_next = 1'b1;
        end
        else if (t_red < -Q30_HALF_PI)
        begin
            t_next    = -Q30_PI - t_red;
            flip_next = 1'b1;
        end
    end

    // Hold the reduced angle in the entry stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg[0] <= t_next;
            x_reg[0] <= Q30_GAIN;
            y_reg[0] <= '0;
            f_reg[0] <= flip_next;
        end
    end

    // Advance one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                f_reg[i+1] <= f_reg[i];
                if (t_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    t_reg[i+1] <= t_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    t_reg[i+1] <= t_reg[i] + atan_q30(i);
                end
            end
        end
    end

    assign sin_q = clamp_one(y_reg[CORDIC_STEPS]);
    assign cos_q = clamp_one(f_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS]
                                                  : x_reg[CORDIC_STEPS]);

endmodule

// File: hdl/hvd_isqrt.sv
// ----------------------------------------------------------------------------
// hvd_isqrt: pipelined digit-by-digit square root of a Q.60 radicand
// One result bit per stage; returns the floor root as a Q.30 value.
// ----------------------------------------------------------------------------
module hvd_isqrt
    import hvd_pkg::*;
(
    input  logic        clk,
    input  logic        adv,
    input  logic [30:0] h,
    output logic [30:0] root
);

    localparam int NS = 31;

    logic [63:0] n_reg   [0:NS];
    logic [63:0] res_reg [0:NS];

    // Load the radicand h << 30
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg[0]   <= {3'b0, h, 30'b0};
            res_reg[0] <= '0;
        end
    end

    // Resolve one root bit per stage
    for (genvar k = 0; k < NS; k++)
    begin : g_sq
        localparam logic [63:0] BIT = 64'd1 << (2 * (NS - 1 - k) + 2);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (n_reg[k] >= res_reg[k] + BIT)
                begin
                    n_reg[k+1]   <= n_reg[k] - (res_reg[k] + BIT);
                    res_reg[k+1] <= (res_reg[k] >> 1) + BIT;
                end
                else
                begin
                    n_reg[k+1]   <= n_reg[k];
                    res_reg[k+1] <= res_reg[k] >> 1;
                end
            end
        end
    end

    // Final shift for the lowest bit position (bit = 1)
    logic [63:0] n_last;
    logic [63:0] r_last;
    always_comb
    begin
        n_last = n_reg[NS];
        if (n_last >= res_reg[NS] + 64'd1)
            r_last = (res_reg[NS] >> 1) + 64'd1;
        else
            r_last = res_reg[NS] >> 1;
        root = r_last[30:0];
    end

endmodule

// File: hdl/hvd_cordic_vec.sv
// ----------------------------------------------------------------------------
// hvd_cordic_vec: pipelined vectoring CORDIC for first-quadrant atan2
// One micro-rotation per stage; output angle clamped to [0, pi/2].
// ----------------------------------------------------------------------------
module hvd_cordic_vec
    import hvd_pkg::*;
(
    input  logic        clk,
    input  logic        adv,
    input  logic [30:0] vy,
    input  logic [30:0] vx,
    output q_t          ang
);

    q_t x_reg [0:CORDIC_STEPS];
    q_t y_reg [0:CORDIC_STEPS];
    q_t z_reg [0:CORDIC_STEPS];

    // Load the vector
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= q_t'({1'b0, vx});
            y_reg[0] <= q_t'({1'b0, vy});
            z_reg[0] <= '0;
        end
    end

    // Advance one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
            end
        end
    end

    always_comb
    begin
        if (z_reg[CORDIC_STEPS] < 0)
            ang = '0;
        else if (z_reg[CORDIC_STEPS] > Q30_HALF_PI)
            ang = Q30_HALF_PI;
        else
            ang = z_reg[CORDIC_STEPS];
    end

endmodule

// File: hdl/haversine_distance_top.sv
// ----------------------------------------------------------------------------
// haversine_distance_top: great-circle distance of two points on a sphere
// Fully pipelined haversine datapath with an APB radius register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries lat_a and lat_b as signed Q2.29
//   and lon_a and lon_b as signed Q3.29 radians. Output channel
//   (out_valid/out_stall) carries distance_m, rounded and saturated. A
//   transfer happens when valid is high and stall is low.
//   Throughput: one pair per cycle while not stalled. From input transfer to
//   output valid the pair passes angle reduce, sin/cos CORDIC, products, two
//   square roots, root register, atan2 CORDIC, scaling and output register.
//   The whole pipeline advances together; when the output register holds an
//   unaccepted result and the receiver stalls, every stage holds and
//   in_stall is raised, so nothing is lost or repeated. Empty bubbles are
//   squeezed out only at the output register.
//   Reset clears all valid bits and sets the radius to 6371000 m. Write the
//   radius at address 0 only while the pipeline is empty.
// ----------------------------------------------------------------------------
module haversine_distance_top
    import hvd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [30:0] lat_a,
    input  logic signed [31:0] lon_a,
    input  logic signed [30:0] lat_b,
    input  logic signed [31:0] lon_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [25:0]        distance_m,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Stages ahead of the output register
    localparam int LAT = 2 * CORDIC_STEPS + 41;

    logic [23:0] radius_reg;
    logic [LAT-1:0] vld_reg;
    logic adv;

    // Advance unless a finished result waits on a stalled receiver
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Radius register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RADIUS) ? {8'b0, radius_reg} : '0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (psel && penable && pwrite && paddr == ADDR_RADIUS)
            radius_reg <= pwdata[23:0];
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // Widen angles to Q.30 and form half differences
    q_t a1, a2, ahl, ahw;
    always_comb
    begin
        a1  = q_t'(lat_a) <<< (30 - ANGLE_FRAC_BITS);
        a2  = q_t'(lat_b) <<< (30 - ANGLE_FRAC_BITS);
        ahl = (q_t'(lat_b) - q_t'(lat_a)) <<< (29 - ANGLE_FRAC_BITS);
        ahw = (q_t'(lon_b) - q_t'(lon_a)) <<< (29 - ANGLE_FRAC_BITS);
    end

    // Wrap modulo 2*pi (only needed when a value exceeds +-2*pi)
    function automatic q_t wrap(input q_t v);
        q_t r;
        r = v;
        if (r >= Q30_TWO_PI)
            r = r - Q30_TWO_PI;
        else if (r <= -Q30_TWO_PI)
            r = r + Q30_TWO_PI;
        return r;
    endfunction

    q_t w1_reg, w2_reg, wl_reg, ww_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_reg <= wrap(a1);
            w2_reg <= wrap(a2);
            wl_reg <= wrap(ahl);
            ww_reg <= wrap(ahw);
        end
    end

    q_t s1, c1, s2, c2, shl, chl, shw, chw;
    hvd_cordic_rot u_r1 (.clk, .adv, .ang(w1_reg), .sin_q(s1), .cos_q(c1));
    hvd_cordic_rot u_r2 (.clk, .adv, .ang(w2_reg), .sin_q(s2), .cos_q(c2));
    hvd_cordic_rot u_rl (.clk, .adv, .ang(wl_reg), .sin_q(shl), .cos_q(chl));
    hvd_cordic_rot u_rw (.clk, .adv, .ang(ww_reg), .sin_q(shw), .cos_q(chw));

    // Products, one multiplier level per stage, then a clamped sum into h
    q_t p_ss_reg, p_cc_reg, p_ww_reg, p_ss2_reg, p_cw_reg, h_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_ss_reg  <= mul_q30(shl, shl);
            p_cc_reg  <= mul_q30(c1, c2);
            p_ww_reg  <= mul_q30(shw, shw);
            p_ss2_reg <= p_ss_reg;
            p_cw_reg  <= mul_q30(p_cc_reg, p_ww_reg);
            if (p_ss2_reg + p_cw_reg < 0)
                h_reg <= '0;
            else if (p_ss2_reg + p_cw_reg > Q30_ONE)
                h_reg <= Q30_ONE;
            else
                h_reg <= p_ss2_reg + p_cw_reg;
        end
    end

    logic [30:0] root_h, root_r;
    q_t rest;
    assign rest = Q30_ONE - h_reg;
    hvd_isqrt u_sq_h (.clk, .adv, .h(h_reg[30:0]), .root(root_h));
    hvd_isqrt u_sq_r (.clk, .adv, .h(rest[30:0]), .root(root_r));

    logic [30:0] rh_reg, rr_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rh_reg <= root_h;
            rr_reg <= root_r;
        end
    end

    q_t ang;
    hvd_cordic_vec u_vec (.clk, .adv, .vy(rh_reg), .vx(rr_reg), .ang(ang));

    // Scale by radius, round and saturate
    logic [54:0] prod_reg;
    logic [25:0] dist_reg;
    logic [54:0] rnd;
    always_comb
    begin
        rnd = (prod_reg + 55'd268435456) >> 29;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= 55'(radius_reg) * 55'(ang[30:0]);
            dist_reg <= (rnd > 55'(DIST_MAX)) ? DIST_MAX : rnd[25:0];
        end
    end

    // Output register
    logic        ov_reg;
    logic [25:0] od_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= vld_reg[LAT-1];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            od_reg <= dist_reg;
    end
    assign out_valid  = ov_reg;
    assign distance_m = od_reg;

    // The pipeline holds whenever a result is stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance_m <= DIST_MAX)
        else $error("distance beyond saturation");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall && vld_reg[LAT-1] |=> out_valid)
        else $error("result dropped");

endmodule

// File: tb/sv/haversine_distance_top_tb.sv
// ----------------------------------------------------------------------------
// haversine_distance_top_tb: self-checking bench for the haversine pipeline
// Writes the sphere radius over APB, feeds point pairs through a directed
// table and a random part, and checks each distance against a fixed-point
// model of the haversine datapath. Input idles and output stalls at random.
// ----------------------------------------------------------------------------
module haversine_distance_top_tb
    import hvd_pkg::*;
();

    localparam int LATENCY     = 98;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 530;

    typedef struct packed {
        logic signed [30:0] lat_a;
        logic signed [31:0] lon_a;
        logic signed [30:0] lat_b;
        logic signed [31:0] lon_b;
    } pair_t;

    typedef struct {
        pair_t       p;
        logic        has_exp;
        logic [25:0] exp_dist;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    logic               out_valid;
    logic               out_stall;
    logic [25:0]        distance_m;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    logic [23:0] radius_m;
    logic [25:0] dist_queue[$];
    int          mismatches;
    int          cycles;
    logic        quiet_phase;
    logic        hold_off;

    haversine_distance_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
        .out_valid(out_valid), .out_stall(out_stall), .distance_m(distance_m),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Distance model
    // ------------------------------------------------------------------
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint prod_q30(longint a, longint b);
        return floor_shift(a * b + 64'sd536870912, 30);
    endfunction

    function automatic longint arctan_step(int i);
        return longint'(atan_q30(i));
    endfunction

    function automatic void rotate_sin_cos(longint ang, output longint s,
                                           output longint c);
        longint t, cx, cy, dx, dy;
        logic   flip;
        t    = ang % longint'(Q30_TWO_PI);
        flip = 1'b0;
        cx   = longint'(Q30_GAIN);
        cy   = 0;
        if (t > longint'(Q30_PI)) t -= longint'(Q30_TWO_PI);
        if (t < -longint'(Q30_PI)) t += longint'(Q30_TWO_PI);
        if (t > longint'(Q30_HALF_PI))
        begin
            t = longint'(Q30_PI) - t;
            flip = 1'b1;
        end
        else if (t < -longint'(Q30_HALF_PI))
        begin
            t = -longint'(Q30_PI) - t;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (t >= 0)
            begin
                cx -= dx; cy += dy; t -= arctan_step(i);
            end
            else
            begin
                cx += dx; cy -= dy; t += arctan_step(i);
            end
        end
        if (flip) cx = -cx;
        s = clip(cy, -longint'(Q30_ONE), longint'(Q30_ONE));
        c = clip(cx, -longint'(Q30_ONE), longint'(Q30_ONE));
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint vy, longint vx);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            dx = floor_shift(vy, i);
            dy = floor_shift(vx, i);
            if (vy >= 0)
            begin
                vx += dx; vy -= dy; z += arctan_step(i);
            end
            else
            begin
                vx -= dx; vy += dy; z -= arctan_step(i);
            end
        end
        return clip(z, 0, longint'(Q30_HALF_PI));
    endfunction

    function automatic logic [25:0] great_circle_m(pair_t p, logic [23:0] r);
        longint la, oa, lb, ob, s1, c1, s2, c2, sh, ch, sw, cw, h, ang;
        longint unsigned d;
        la = longint'(p.lat_a);
        oa = longint'(p.lon_a);
        lb = longint'(p.lat_b);
        ob = longint'(p.lon_b);
        rotate_sin_cos(la * 2, s1, c1);
        rotate_sin_cos(lb * 2, s2, c2);
        rotate_sin_cos(lb - la, sh, ch);
        rotate_sin_cos(ob - oa, sw, cw);
        h = prod_q30(sh, sh) + prod_q30(prod_q30(c1, c2), prod_q30(sw, sw));
        h = clip(h, 0, longint'(Q30_ONE));
        ang = vector_angle(int_sqrt(longint'(h) << 30),
                           int_sqrt((longint'(Q30_ONE) - h) << 30));
        d = (longint'(r) * ang + (64'sd1 << 28)) >> 29;
        if (d > longint'(DIST_MAX)) d = DIST_MAX;
        return d[25:0];
    endfunction

    // ------------------------------------------------------------------
    // Register writes and stimulus helpers
    // ------------------------------------------------------------------
    task automatic apb_write(logic [1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RADIUS) radius_m = data[23:0];
    endtask

    // Drop the input, wait for all results and read back the radius
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (dist_queue.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (prdata !== {8'b0, radius_m})
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("prdata expected %0d got %0d", radius_m, prdata);
        end
    endtask

    // Offer one pair and hold it until the transfer
    task automatic send_pair(pair_t p, logic has_exp, logic [25:0] exp_d);
        logic [25:0] want_d;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        lat_a <= p.lat_a;
        lon_a <= p.lon_a;
        lat_b <= p.lat_b;
        lon_b <= p.lon_b;
        do @(posedge clk); while (in_stall);
        want_d = has_exp ? exp_d : great_circle_m(p, radius_m);
        dist_queue = {dist_queue, want_d};
    endtask

    function automatic pair_t random_pair();
        pair_t        p;
        logic [127:0] raw;
        case ($urandom_range(0, 5))
            0:
            begin
                raw = {$urandom, $urandom, $urandom, $urandom};
                p = raw[125:0];
            end
            1:
            begin
                p.lat_a = 31'($urandom_range(0, 1686629714) - 843314857);
                p.lat_b = 31'(p.lat_a + $signed($urandom_range(0, 2000)) - 1000);
                p.lon_a = $urandom_range(0, 2000000000) - 1000000000;
                p.lon_b = p.lon_a + $signed($urandom_range(0, 2000)) - 1000;
            end
            default:
            begin
                p.lat_a = 31'($urandom_range(0, 1686629714) - 843314857);
                p.lat_b = 31'($urandom_range(0, 1686629714) - 843314857);
                p.lon_a = $urandom_range(0, 2147483647) - 1686629713;
                p.lon_b = $urandom_range(0, 2147483647) - 1686629713;
                if ($urandom_range(0, 1)) p.lon_a = -p.lon_a;
            end
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [25:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (dist_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected distance_m %0d", distance_m);
            end
            else
            begin
                want = dist_queue.pop_front();
                if (distance_m !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("distance_m expected %0d got %0d", want, distance_m);
                end
            end
        end
    end

    initial
    begin
        int burst;
        out_stall <= 1'b0;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(0, 6);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Long receiver hold-off so the pipeline fills and backs up
    task automatic long_hold_off();
        hold_off = 1'b1;
        repeat (LATENCY * 3) @(posedge clk);
        hold_off = 1'b0;
    endtask

    // Cycle watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t    table_rows[$];
        dir_row_t    row;
        logic [23:0] radius_set[5];
        int          phase_items;
        logic signed [30:0] lat_top;
        logic signed [31:0] lon_top;

        rst_n = 1'b0;
        in_valid = 1'b0; lat_a = '0; lon_a = '0; lat_b = '0; lon_b = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0; cycles = 0; quiet_phase = 1'b0; hold_off = 1'b0;
        radius_m = RADIUS_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        lat_top = 31'sd843314857;
        lon_top = 32'sd1686629713;
        // Directed table: identical points give zero, others use the model
        table_rows = '{
            '{'{31'sd0, 32'sd0, 31'sd0, 32'sd0}, 1'b1, 26'd0},
            '{'{lat_top, lon_top, lat_top, lon_top}, 1'b1, 26'd0},
            '{'{-lat_top, -lon_top, -lat_top, -lon_top}, 1'b1, 26'd0},
            '{'{lat_top, 32'sd0, -lat_top, 32'sd0}, 1'b0, 26'd0},
            '{'{31'sd0, -lon_top, 31'sd0, lon_top}, 1'b0, 26'd0},
            '{'{31'sd0, 32'sd0, 31'sd0, lon_top}, 1'b0, 26'd0},
            '{'{31'sd0, 32'sd1, 31'sd0, 32'sd0}, 1'b0, 26'd0},
            '{'{31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000}, 1'b0, 26'd0},
            '{'{31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF}, 1'b0, 26'd0},
            '{'{31'h7FFFFFFF, 32'hFFFFFFFF, 31'h55555555, 32'hAAAAAAAA}, 1'b0, 26'd0},
            '{'{31'h2AAAAAAA, 32'h55555555, 31'sd0, 32'sd0}, 1'b0, 26'd0},
            '{'{31'sd281104952, 32'sd1234567, -31'sd281104952, -32'sd987654}, 1'b0, 26'd0}
        };
        foreach (table_rows[i])
        begin
            row = table_rows[i];
            send_pair(row.p, row.has_exp, row.exp_dist);
        end
        drain_pipeline();

        // Radius settings: extremes, zero, 12345 m and the Earth again
        radius_set = '{24'd1, 24'hFFFFFF, 24'd0, 24'd12345, RADIUS_RESET};
        foreach (radius_set[k])
        begin
            apb_write(ADDR_RADIUS, {8'hA5, radius_set[k]});
            phase_items = (k == 4) ? N_RANDOM - 4 * 80 : 80;
            for (int n = 0; n < phase_items; n++)
            begin
                if (k == 1 && n == 20)
                    fork
                        long_hold_off();
                    join_none
                if (k == 4 && n == phase_items - 60) quiet_phase = 1'b1;
                send_pair(random_pair(), 1'b0, 26'd0);
            end
            drain_pipeline();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
hdl/hvd_pkg.sv
hdl/hvd_cordic_rot.sv
hdl/hvd_isqrt.sv
hdl/hvd_cordic_vec.sv
hdl/haversine_distance_top.sv
tb/sv/haversine_distance_top_tb.sv
